@@ rtl/ecfr_pkg.sv @@
// Package for the edge count frame receiver: sizes, constants, state codes
// and small helpers. No dependencies.
`default_nettype none
package ecfr_pkg;
  localparam int MAX_PAYLOAD   = 32;
  localparam int CAPTURE_BITS  = 304;
  localparam int KEY_MAX_BYTES = 8;
  localparam int PRE_SLOTS     = 32;
  localparam int ADDR_W        = $clog2(CAPTURE_BITS + 1);
  localparam int PADDR_W       = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam logic [31:0] PREAMBLE = 32'hAA55AA55;
  localparam logic [7:0]  CRC_POLY = 8'h07;
  localparam logic [16:0] MIN_SEP  = 17'd2;
  localparam int LAST_POS = CAPTURE_BITS - PRE_SLOTS - 16;

  localparam logic [1:0] CFG_KEY   = 2'd0;
  localparam logic [1:0] CFG_KLEN  = 2'd1;
  localparam logic [1:0] CFG_MAXL  = 2'd2;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_LONG   = 2'd1;
  localparam logic [1:0] ST_NONE   = 2'd2;
  localparam logic [1:0] ST_CRCBAD = 2'd3;

  typedef enum logic [3:0] {
    S_FILL, S_SUM, S_SUMW, S_MEAN, S_BYTE, S_BYTEW, S_BYTED, S_KEY, S_CHECK,
    S_EMIT, S_EMITW, S_DONE
  } state_t;

  // datapath commands
  typedef struct packed {
    logic sum_clr;    // clear sums, start preamble read
    logic sum_rd;     // issue preamble read
    logic byte_clr;   // start reading a byte
    logic byte_rd;    // issue bit read
    logic take_len;
    logic take_pay;
    logic key_step;
    logic pos_inc;
    logic pos_clr;    // restart scan at position zero
    logic emit_rd;
    logic crc_clr;
  } cmd_t;

  typedef struct packed {
    logic sum_done;
    logic sep_ok;
    logic byte_done;
    logic len_ok;
    logic pay_done;
    logic key_done;
    logic crc_ok;
    logic pos_last;
  } sts_t;

  function automatic logic [7:0] crc_feed(input logic [7:0] crc, input logic [7:0] v);
    logic [7:0] c;
    c = crc ^ v;
    for (int k = 0; k < 8; k++) c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    return c;
  endfunction
endpackage
`default_nettype wire

@@ rtl/ecfr_ram.sv @@
// Generic single port write, single read RAM with registered read data.
// No dependencies.
`default_nettype none
module ecfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ rtl/ecfr_datapath.sv @@
// Datapath: capture store, preamble sums, bit classifier, CRC, payload store.
// Uses ecfr_pkg and ecfr_ram.
`default_nettype none
module ecfr_datapath import ecfr_pkg::*; (
  input  wire logic                clk,
  input  wire logic                fill_we,
  input  wire logic [ADDR_W-1:0]   fill_addr,
  input  wire logic [15:0]         fill_data,
  input  wire cmd_t                cmd,
  input  wire logic [63:0]         key_bytes,
  input  wire logic [3:0]          key_length,
  output sts_t                     sts,
  output logic [7:0]               len_q,
  output logic [7:0]               emit_byte,
  output logic [PADDR_W:0]         emit_idx
);
  logic [ADDR_W-1:0] pos_r, pos_nxt;
  logic [5:0]  sidx_r, sidx_nxt;      // preamble slot issue index
  logic [5:0]  sret_r, sret_nxt;      // returned count
  logic [19:0] s0_r, s0_nxt, s1_r, s1_nxt;
  logic [15:0] m0_r, m0_nxt, m1_r, m1_nxt;
  logic [3:0]  bidx_r, bidx_nxt, bret_r, bret_nxt;
  logic [7:0]  shf_r, shf_nxt;
  logic [ADDR_W-1:0] baddr_r, baddr_nxt;
  logic [PADDR_W:0]  pcnt_r, pcnt_nxt;
  logic [7:0]  crc_r, crc_nxt, len_r, len_nxt;
  logic [3:0]  kcnt_r, kcnt_nxt;
  logic        rd_v_r, rd_v_nxt, sum_v_r, sum_v_nxt;
  logic [PADDR_W:0] eidx_r, eidx_nxt;

  logic [ADDR_W-1:0] raddr;
  logic [15:0] rdata;
  logic [7:0]  prd;
  logic [3:0]  klen;
  logic        bitv;
  logic [16:0] d1, d0;

  ecfr_ram #(.WIDTH(16), .DEPTH(CAPTURE_BITS), .AW(ADDR_W)) u_edge (
    .clk, .we(fill_we), .waddr(fill_addr), .wdata(fill_data),
    .raddr(raddr), .rdata(rdata));

  ecfr_ram #(.WIDTH(8), .DEPTH(MAX_PAYLOAD), .AW(PADDR_W)) u_pay (
    .clk, .we(cmd.take_pay), .waddr(pcnt_r[PADDR_W-1:0]), .wdata(shf_r),
    .raddr(eidx_nxt[PADDR_W-1:0]), .rdata(prd));

  assign raddr = cmd.byte_rd ? baddr_r : pos_r + ADDR_W'(sidx_r);
  assign klen  = (key_length > 4'(KEY_MAX_BYTES)) ? 4'(KEY_MAX_BYTES) : key_length;

  assign d1   = (rdata > m1_r) ? 17'(rdata) - 17'(m1_r) : 17'(m1_r) - 17'(rdata);
  assign d0   = (rdata > m0_r) ? 17'(rdata) - 17'(m0_r) : 17'(m0_r) - 17'(rdata);
  assign bitv = d1 < d0;

  always_comb begin
    pos_nxt = pos_r; sidx_nxt = sidx_r; sret_nxt = sret_r;
    s0_nxt = s0_r; s1_nxt = s1_r; m0_nxt = m0_r; m1_nxt = m1_r;
    bidx_nxt = bidx_r; bret_nxt = bret_r; shf_nxt = shf_r; baddr_nxt = baddr_r;
    pcnt_nxt = pcnt_r; crc_nxt = crc_r; len_nxt = len_r; kcnt_nxt = kcnt_r;
    rd_v_nxt = 1'b0; sum_v_nxt = 1'b0; eidx_nxt = eidx_r;
    if (cmd.sum_clr) begin
      sidx_nxt = '0; sret_nxt = '0; s0_nxt = '0; s1_nxt = '0;
    end
    if (cmd.sum_rd && sidx_r < 6'(PRE_SLOTS)) begin
      sidx_nxt = sidx_r + 6'd1; sum_v_nxt = 1'b1;
    end
    if (sum_v_r) begin
      if (PREAMBLE[5'(31 - sret_r)]) s1_nxt = s1_r + 20'(rdata);
      else s0_nxt = s0_r + 20'(rdata);
      sret_nxt = sret_r + 6'd1;
    end
    if (sret_r == 6'(PRE_SLOTS) && cmd.sum_rd) begin
      m0_nxt = s0_r[19:4]; m1_nxt = s1_r[19:4];
    end
    if (cmd.byte_clr) begin
      bidx_nxt = '0; bret_nxt = '0;
      baddr_nxt = cmd.take_len ? pos_r + ADDR_W'(PRE_SLOTS) : baddr_r;
    end
    if (cmd.byte_rd && bidx_r < 4'd8) begin
      baddr_nxt = baddr_r + ADDR_W'(1); bidx_nxt = bidx_r + 4'd1; rd_v_nxt = 1'b1;
    end
    if (rd_v_r) begin
      shf_nxt = {shf_r[6:0], bitv}; bret_nxt = bret_r + 4'd1;
    end
    if (cmd.crc_clr) begin
      len_nxt = shf_r; crc_nxt = crc_feed(8'h00, shf_r); pcnt_nxt = '0; kcnt_nxt = '0;
    end
    if (cmd.take_pay) begin
      crc_nxt = crc_feed(crc_r, shf_r); pcnt_nxt = pcnt_r + 1'b1;
    end
    if (cmd.key_step && kcnt_r < klen) begin
      crc_nxt = crc_feed(crc_r, key_bytes[{kcnt_r[2:0], 3'b000} +: 8]);
      kcnt_nxt = kcnt_r + 4'd1;
    end
    if (cmd.pos_inc) pos_nxt = pos_r + ADDR_W'(1);
    if (cmd.pos_clr) pos_nxt = '0;
    if (cmd.emit_rd) eidx_nxt = eidx_r + 1'b1;
    else if (cmd.crc_clr) eidx_nxt = '0;
  end

  always_ff @(posedge clk) begin
    pos_r <= pos_nxt; sidx_r <= sidx_nxt; sret_r <= sret_nxt;
    s0_r <= s0_nxt; s1_r <= s1_nxt; m0_r <= m0_nxt; m1_r <= m1_nxt;
    bidx_r <= bidx_nxt; bret_r <= bret_nxt; shf_r <= shf_nxt; baddr_r <= baddr_nxt;
    pcnt_r <= pcnt_nxt; crc_r <= crc_nxt; len_r <= len_nxt; kcnt_r <= kcnt_nxt;
    rd_v_r <= rd_v_nxt; sum_v_r <= sum_v_nxt; eidx_r <= eidx_nxt;
  end

  always_comb begin
    sts.sum_done  = sret_r == 6'(PRE_SLOTS);
    sts.sep_ok    = ((m0_r > m1_r) ? 17'(m0_r) - 17'(m1_r) : 17'(m1_r) - 17'(m0_r))
                    >= MIN_SEP;
    sts.byte_done = bret_r == 4'd8;
    sts.len_ok    = shf_r != 8'd0 && shf_r <= 8'(MAX_PAYLOAD) &&
                    (ADDR_W+9)'(pos_r) + (ADDR_W+9)'(PRE_SLOTS + 16)
                    + (ADDR_W+9)'({shf_r, 3'b000}) <= (ADDR_W+9)'(CAPTURE_BITS);
    sts.pay_done  = (PADDR_W+1)'(len_r) == pcnt_r;
    sts.key_done  = kcnt_r >= klen;
    sts.crc_ok    = crc_r == shf_r;
    sts.pos_last  = pos_r == ADDR_W'(LAST_POS);
  end

  assign len_q     = len_r;
  assign emit_byte = prd;
  assign emit_idx  = eidx_r;
endmodule
`default_nettype wire

@@ rtl/ecfr_ctrl.sv @@
// Controller state machine for the scan: sequences datapath commands and
// drives the result strobe. Uses ecfr_pkg.
`default_nettype none
module ecfr_ctrl import ecfr_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  full,
  input  wire sts_t  sts,
  input  wire logic [7:0] len_q,
  input  wire logic [5:0] max_len,
  input  wire logic [PADDR_W:0] emit_idx,
  output cmd_t       cmd,
  output logic       busy,
  output logic       res_v,
  output logic [1:0] res_st,
  output logic       res_pay,
  output logic       res_last
);
  state_t state_r, state_nxt;
  logic bad_r, bad_nxt, first_r, first_nxt;

  always_comb begin
    state_nxt = state_r; bad_nxt = bad_r; first_nxt = first_r;
    case (state_r)
      S_FILL:  if (full) begin state_nxt = S_SUM; bad_nxt = 1'b0; end
      S_SUM:   state_nxt = S_SUMW;
      S_SUMW:  if (sts.sum_done) state_nxt = S_MEAN;
      S_MEAN:  begin
        state_nxt = sts.sep_ok ? S_BYTE : (sts.pos_last ? S_DONE : S_SUM);
        first_nxt = 1'b1;
      end
      S_BYTE:  state_nxt = S_BYTEW;
      S_BYTEW: if (sts.byte_done) state_nxt = S_BYTED;
      S_BYTED: begin
        if (first_r) begin
          first_nxt = 1'b0;
          if (!sts.len_ok) state_nxt = sts.pos_last ? S_DONE : S_SUM;
          else state_nxt = S_BYTE;
        end else if (!sts.pay_done) state_nxt = S_BYTE;
        else state_nxt = S_CHECK;
      end
      S_CHECK: begin
        state_nxt = S_KEY;
      end
      S_KEY:   if (sts.key_done) begin
        if (sts.crc_ok) state_nxt = S_EMIT;
        else begin
          bad_nxt = 1'b1;
          state_nxt = sts.pos_last ? S_DONE : S_SUM;
        end
      end
      S_EMIT:  state_nxt = (len_q > {2'b00, max_len}) ? S_FILL : S_EMITW;
      S_EMITW: if (emit_idx == (PADDR_W+1)'(len_q) - 1'b1) state_nxt = S_FILL;
      S_DONE:  state_nxt = S_FILL;
      default: state_nxt = S_FILL;
    endcase
  end

  always_comb begin
    cmd = '0; res_v = 1'b0; res_st = ST_OK; res_pay = 1'b0; res_last = 1'b0;
    case (state_r)
      S_FILL:  if (full) begin cmd.sum_clr = 1'b1; cmd.pos_clr = 1'b1; end
      S_SUM:   cmd.sum_rd = 1'b1;
      S_SUMW:  cmd.sum_rd = 1'b1;
      S_MEAN:  if (sts.sep_ok) begin cmd.byte_clr = 1'b1; cmd.take_len = 1'b1; end
               else begin cmd.sum_clr = 1'b1; cmd.pos_inc = 1'b1; end
      S_BYTE:  cmd.byte_rd = 1'b1;
      S_BYTEW: cmd.byte_rd = 1'b1;
      S_BYTED: begin
        if (first_r) begin
          if (!sts.len_ok) begin cmd.sum_clr = 1'b1; cmd.pos_inc = 1'b1; end
          else begin cmd.crc_clr = 1'b1; cmd.byte_clr = 1'b1; end
        end else if (!sts.pay_done) begin
          cmd.take_pay = 1'b1; cmd.byte_clr = 1'b1;
        end else cmd.byte_clr = 1'b1;
      end
      S_KEY:   begin
        cmd.key_step = 1'b1;
        if (sts.key_done && !sts.crc_ok) begin cmd.sum_clr = 1'b1; cmd.pos_inc = 1'b1; end
      end
      S_EMIT:  if (len_q > {2'b00, max_len}) begin
        res_v = 1'b1; res_st = ST_LONG; res_last = 1'b1;
      end
      S_EMITW: begin
        res_v = 1'b1; res_pay = 1'b1; cmd.emit_rd = 1'b1;
        res_last = emit_idx == (PADDR_W+1)'(len_q) - 1'b1;
      end
      S_DONE:  begin
        res_v = 1'b1; res_st = bad_r ? ST_CRCBAD : ST_NONE; res_last = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_FILL; bad_r <= 1'b0; first_r <= 1'b0;
    end else begin
      state_r <= state_nxt; bad_r <= bad_nxt; first_r <= first_nxt;
    end
  end

  assign busy = state_r != S_FILL;

  a_last_needs_v: assert property (@(posedge clk) disable iff (!rst_n)
    res_last |-> res_v) else $error("last without strobe");
  a_done_goes_fill: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DONE |=> state_r == S_FILL) else $error("done not followed by fill");
  a_no_cmd_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FILL) |-> !res_v) else $error("result while filling");
endmodule
`default_nettype wire

@@ rtl/edge_count_frame_receiver_unit.sv @@
// Top level of the edge count frame receiver: config registers, capture fill
// counter, controller and datapath. Uses ecfr_pkg, ecfr_ctrl, ecfr_datapath.
// One edge count is taken per cycle while start is high and busy is low. The
// item that fills the 304 slot window raises busy; the scan then reads the
// store one slot per cycle for each candidate position and each byte of a
// candidate frame, and puts results out on out_valid, one per cycle, which
// cannot be held off. busy falls after the last result.
`default_nettype none
module edge_count_frame_receiver_unit import ecfr_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [15:0] in_edge_count,
  output logic             out_valid,
  output logic [1:0]       out_status,
  output logic [7:0]       out_payload_byte,
  output logic [5:0]       out_frame_length,
  output logic             out_last,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);
  logic [63:0] key_r;
  logic [3:0]  klen_r;
  logic [5:0]  maxl_r;
  logic [ADDR_W-1:0] fill_r, fill_nxt;
  logic acc, full, res_v, res_pay, res_last;
  logic [1:0] res_st;
  logic [7:0] len_q, eb;
  logic [PADDR_W:0] eidx;
  cmd_t cmd;
  sts_t sts;

  assign acc  = start && !busy;
  assign full = acc && fill_r == ADDR_W'(CAPTURE_BITS - 1);
  assign fill_nxt = full ? '0 : (acc ? fill_r + ADDR_W'(1) : fill_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0; klen_r <= '0; maxl_r <= 6'd32; fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_KEY:  key_r  <= cfg_data;
          CFG_KLEN: klen_r <= cfg_data[3:0];
          CFG_MAXL: maxl_r <= cfg_data[5:0];
          default: ;
        endcase
      end
    end
  end

  ecfr_ctrl u_ctrl (.clk, .rst_n, .full, .sts, .len_q, .max_len(maxl_r),
    .emit_idx(eidx), .cmd, .busy, .res_v, .res_st, .res_pay, .res_last);

  ecfr_datapath u_dp (.clk, .fill_we(acc), .fill_addr(fill_r), .fill_data(in_edge_count),
    .cmd, .key_bytes(key_r), .key_length(klen_r), .sts, .len_q, .emit_byte(eb),
    .emit_idx(eidx));

  assign out_valid        = res_v;
  assign out_status       = res_st;
  assign out_payload_byte = res_pay ? eb : 8'd0;
  assign out_frame_length = res_pay ? len_q[5:0] : 6'd0;
  assign out_last         = res_last;
endmodule
`default_nettype wire
